[rtl/r2fft_pkg.sv]
// Package for the radix-2 frame FFT: widths, saturation, twiddle table and state type.
// No dependencies.
package r2fft_pkg;

  localparam int PointsDefault = 64;
  localparam int SampleW = 16;
  localparam int BinW = 23;
  localparam int TwW = 16;
  localparam logic signed [BinW-1:0] SatMax = 23'sd4194303;
  localparam logic signed [BinW-1:0] SatMin = -23'sd4194304;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_Y,
    ST_RD_X,
    ST_WR_Y,
    ST_WR_X,
    ST_OUT_RD,
    ST_OUT_WAIT
  } state_t;

  function automatic logic signed [TwW-1:0] quarter_cos(input logic [4:0] k);
    logic signed [TwW-1:0] v;
    begin
      unique case (k)
        5'd0:  v = 16'sd32767;
        5'd1:  v = 16'sd32610;
        5'd2:  v = 16'sd32138;
        5'd3:  v = 16'sd31357;
        5'd4:  v = 16'sd30274;
        5'd5:  v = 16'sd28899;
        5'd6:  v = 16'sd27246;
        5'd7:  v = 16'sd25330;
        5'd8:  v = 16'sd23170;
        5'd9:  v = 16'sd20788;
        5'd10: v = 16'sd18205;
        5'd11: v = 16'sd15447;
        5'd12: v = 16'sd12540;
        5'd13: v = 16'sd9512;
        5'd14: v = 16'sd6393;
        5'd15: v = 16'sd3212;
        default: v = 16'sd0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [BinW-1:0] sat23(input logic signed [BinW+1:0] v);
    begin
      if (v > 25'(SatMax)) return SatMax;
      if (v < 25'(SatMin)) return SatMin;
      return v[BinW-1:0];
    end
  endfunction

endpackage

[rtl/radix2_fft_frame_unit.sv]
// Channel | dir | beat contents
// in      | in  | tdata: sample_re[15:0], sample_im[31:16]
// out     | out | tdata: bin_re[22:0], bin_im[45:23], bin_index[51:46]; tlast: last_bin
// cfg     | in  | data: inverse
// Samples are taken while in ST_LOAD; the last sample of a frame starts the transform.
// Each butterfly runs ST_RD_Y, ST_RD_X, ST_WR_Y, ST_WR_X on the single-port work RAM
// (two reads and two writes) and one shared complex multiplier; a 64-point frame has
// 192 butterflies. Bins are read in ST_OUT_RD and held in ST_OUT_WAIT on stalls. Input
// and configuration are held off from a frame's last sample until its last bin has left.
// Reset (rst_n, synchronous) clears the sequencer, load count and inverse.
// Top level of the radix-2 frame FFT and its port checker; uses r2fft_pkg and r2fft_ram.
module radix2_fft_frame_unit #(
  parameter int POINTS = r2fft_pkg::PointsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // sample_re, sample_im
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // bin_re, bin_im, bin_index, zero fill
  output logic        out_tlast,  // last_bin
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int Bits = (POINTS >= 64) ? 6 : (POINTS >= 32) ? 5 : (POINTS >= 16) ? 4 :
                        (POINTS >= 8) ? 3 : (POINTS >= 4) ? 2 : 1;
  localparam int N = 1 << Bits;
  localparam int BinW = r2fft_pkg::BinW;
  localparam int SW = r2fft_pkg::SampleW;

  r2fft_pkg::state_t state_r, state_nxt;
  logic [Bits-1:0] cnt_r, cnt_nxt;
  logic [2:0] stg_r, stg_nxt;
  logic [Bits-1:0] bfly_r, bfly_nxt;
  logic inverse_r;
  logic signed [BinW-1:0] xre_r, xim_r;
  logic signed [BinW:0] tre_r, tim_r;
  logic [5:0] oidx_r;
  logic olast_r;

  logic ram_we;
  logic [Bits-1:0] ram_addr;
  logic [2*BinW-1:0] ram_wdata, ram_rdata;
  logic signed [BinW-1:0] rd_re, rd_im;

  r2fft_ram #(.Width(2*BinW), .Depth(N)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign rd_re = ram_rdata[BinW-1:0];
  assign rd_im = ram_rdata[2*BinW-1:BinW];

  // Butterfly addressing: m = 2^stg, j = low stg bits of bfly.
  logic [Bits-1:0] mmask, jv, xaddr, yaddr, rev_cnt;
  logic [4:0] tw_k;
  logic signed [r2fft_pkg::TwW-1:0] tw_c, tw_s;
  always_comb begin
    mmask = Bits'((1 << stg_r) - 1);
    jv = bfly_r & mmask;
    xaddr = ((bfly_r & ~mmask) << 1) | jv;
    yaddr = xaddr | Bits'(1 << stg_r);
    tw_k = 5'((11'(jv) << 5) >> stg_r);
    for (int i = 0; i < Bits; i++) rev_cnt[i] = cnt_r[Bits-1-i];
    if (tw_k <= 5'd16) begin
      tw_c = r2fft_pkg::quarter_cos(tw_k);
      tw_s = r2fft_pkg::quarter_cos(5'(5'd16 - tw_k));
    end else begin
      tw_c = -r2fft_pkg::quarter_cos(5'(6'd32 - {1'b0, tw_k}));
      tw_s = r2fft_pkg::quarter_cos(5'(tw_k - 5'd16));
    end
  end

  logic signed [r2fft_pkg::TwW-1:0] tw_d;
  logic signed [BinW+r2fft_pkg::TwW+1:0] pre, pim;
  assign tw_d = inverse_r ? tw_s : -tw_s;
  assign pre = (rd_re * tw_c) - (rd_im * tw_d) + 41'sd16384;
  assign pim = (rd_re * tw_d) + (rd_im * tw_c) + 41'sd16384;

  logic signed [BinW+1:0] sum_re, sum_im, dif_re, dif_im;
  assign sum_re = 25'(xre_r) + 25'(tre_r);
  assign sum_im = 25'(xim_r) + 25'(tim_r);
  assign dif_re = 25'(rd_re) - 25'(tre_r);
  assign dif_im = 25'(rd_im) - 25'(tim_r);

  logic last_bfly, last_stg;
  assign last_bfly = (bfly_r == Bits'(N/2 - 1));
  assign last_stg = (stg_r == 3'(Bits - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    stg_nxt = stg_r;
    bfly_nxt = bfly_r;
    unique case (state_r)
      r2fft_pkg::ST_LOAD: begin
        if (in_tvalid) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == Bits'(N-1)) begin
            state_nxt = r2fft_pkg::ST_RD_Y;
            stg_nxt = '0;
            bfly_nxt = '0;
          end
        end
      end
      r2fft_pkg::ST_RD_Y: state_nxt = r2fft_pkg::ST_RD_X;
      r2fft_pkg::ST_RD_X: state_nxt = r2fft_pkg::ST_WR_Y;
      r2fft_pkg::ST_WR_Y: state_nxt = r2fft_pkg::ST_WR_X;
      r2fft_pkg::ST_WR_X: begin
        bfly_nxt = bfly_r + 1'b1;
        state_nxt = r2fft_pkg::ST_RD_Y;
        if (last_bfly) begin
          bfly_nxt = '0;
          stg_nxt = stg_r + 1'b1;
          if (last_stg) begin
            state_nxt = r2fft_pkg::ST_OUT_RD;
            cnt_nxt = '0;
          end
        end
      end
      r2fft_pkg::ST_OUT_RD: state_nxt = r2fft_pkg::ST_OUT_WAIT;
      r2fft_pkg::ST_OUT_WAIT: begin
        if (out_tready) begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = (cnt_r == Bits'(N-1)) ? r2fft_pkg::ST_LOAD : r2fft_pkg::ST_OUT_RD;
        end
      end
      default: state_nxt = r2fft_pkg::ST_LOAD;
    endcase
  end

  // The y result is written first, while the x word is still on the read port;
  // the x result follows from the captured x word.
  always_comb begin
    ram_we = 1'b0;
    ram_addr = xaddr;
    ram_wdata = {r2fft_pkg::sat23(sum_im), r2fft_pkg::sat23(sum_re)};
    in_tready = (state_r == r2fft_pkg::ST_LOAD);
    unique case (state_r)
      r2fft_pkg::ST_LOAD: begin
        ram_we = in_tvalid;
        ram_addr = rev_cnt;
        ram_wdata = {BinW'($signed(in_tdata[2*SW-1:SW])), BinW'($signed(in_tdata[SW-1:0]))};
      end
      r2fft_pkg::ST_RD_Y: ram_addr = yaddr;
      r2fft_pkg::ST_RD_X: ram_addr = xaddr;
      r2fft_pkg::ST_WR_Y: begin
        ram_we = 1'b1;
        ram_addr = yaddr;
        ram_wdata = {r2fft_pkg::sat23(dif_im), r2fft_pkg::sat23(dif_re)};
      end
      r2fft_pkg::ST_WR_X: begin
        ram_we = 1'b1;
        ram_addr = xaddr;
      end
      r2fft_pkg::ST_OUT_RD, r2fft_pkg::ST_OUT_WAIT: ram_addr = cnt_r;
      default: ram_addr = xaddr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= r2fft_pkg::ST_LOAD;
      cnt_r <= '0;
      stg_r <= '0;
      bfly_r <= '0;
      inverse_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      stg_r <= stg_nxt;
      bfly_r <= bfly_nxt;
      if (cfg_valid && cfg_ready) inverse_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == r2fft_pkg::ST_RD_X) begin
      tre_r <= (BinW+1)'(pre >>> 15);
      tim_r <= (BinW+1)'(pim >>> 15);
    end
    if (state_r == r2fft_pkg::ST_WR_Y) begin
      xre_r <= rd_re;
      xim_r <= rd_im;
    end
    if (state_r == r2fft_pkg::ST_OUT_RD) begin
      oidx_r <= 6'(cnt_r);
      olast_r <= (cnt_r == Bits'(N-1));
    end
  end

  assign cfg_ready = (state_r == r2fft_pkg::ST_LOAD);
  assign out_tvalid = (state_r == r2fft_pkg::ST_OUT_WAIT);
  assign out_tdata = {4'b0, oidx_r, rd_im, rd_re};
  assign out_tlast = olast_r;

endmodule

module radix2_fft_frame_unit_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid);

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast));

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid));

  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid);

endmodule

bind radix2_fft_frame_unit radix2_fft_frame_unit_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tlast(out_tlast)
);

[rtl/r2fft_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module r2fft_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
